[rtl/core/periodic_task_timer_table_assert.svh]
// Assertion macros for the periodic task timer table.
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PTT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/ptt_pkg.sv]
// Package with types, codes and sizes of the periodic task timer table.
package ptt_pkg;
    localparam int TASK_SLOTS  = 8;
    localparam int RING_DEPTH  = 8;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int RING_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam logic [7:0] FREE_ID = 8'd255;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0, MODE_REMOVE = 3'd1, MODE_SET = 3'd2,
        MODE_TICK = 3'd3, MODE_ENQ = 3'd4, MODE_POLL = 3'd5
    } mode_t;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_DRAIN  = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_SLOT = 3'd1;
    localparam logic [2:0] ST_DUP = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_BAD_INTERVAL = 3'd4;
    localparam logic [2:0] ST_INVALID_ID = 3'd5;
    localparam logic [2:0] ST_FULL = 3'd6;

    localparam logic CFG_MIN = 1'b0;
    localparam logic CFG_MAX = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  task_id;
        logic [15:0] interval;
        logic [15:0] token;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [7:0]  fired_id;
        logic [15:0] handle;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  ident;
        logic        pending;
        logic [15:0] period;
        logic [15:0] remaining;
        logic [15:0] handle;
    } slot_t;

    // Command broadcast to all cells of the chain at once.
    typedef struct packed {
        logic        tick;
        logic        add;
        logic        remove;
        logic        set;
        logic        fire;
        logic [15:0] interval;
        logic [15:0] token;
        logic [7:0]  task_id;
    } cell_cmd_t;

    // Search token that runs along the chain.
    typedef struct packed {
        logic       found;
        logic       have_free;
        logic       have_pend;
    } chain_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DRAIN, ST_FIRE, ST_DONE, ST_OUT
    } fsm_t;
endpackage

[rtl/core/ptt_cell.sv]
// One timer slot cell of the chain.
module ptt_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  ptt_pkg::cell_cmd_t cmd,
    input  logic              sel_add,
    input  logic              sel_fire,
    input  ptt_pkg::chain_t   chain_in,
    output ptt_pkg::chain_t   chain_out,
    output logic              is_free,
    output logic              is_pend,
    output ptt_pkg::slot_t    slot
);
    import ptt_pkg::*;

    logic [7:0]  ident_reg, ident_next;
    logic        pend_reg, pend_next;
    logic [15:0] period_reg, period_next, rem_reg, rem_next, handle_reg, handle_next;
    logic [15:0] dec;
    logic        match;

    assign match   = (ident_reg == cmd.task_id);
    assign is_free = (ident_reg == FREE_ID);
    assign is_pend = !is_free && pend_reg;
    assign chain_out.found     = chain_in.found | match;
    assign chain_out.have_free = chain_in.have_free | is_free;
    assign chain_out.have_pend = chain_in.have_pend | is_pend;
    assign dec = rem_reg - 16'd1;
    assign slot = '{ident: ident_reg, pending: pend_reg, period: period_reg,
                    remaining: rem_reg, handle: handle_reg};

    always_comb
    begin
        ident_next = ident_reg; pend_next = pend_reg; period_next = period_reg;
        rem_next = rem_reg; handle_next = handle_reg;
        if (cmd.add && sel_add)
        begin
            ident_next = cmd.task_id; pend_next = 1'b0; period_next = cmd.interval;
            rem_next = cmd.interval; handle_next = cmd.token;
        end
        if (cmd.remove && match) ident_next = FREE_ID;
        if (cmd.set && match) period_next = cmd.interval;
        if (cmd.tick && !is_free && !pend_reg)
        begin
            rem_next = dec;
            pend_next = (dec == 16'd0);
        end
        if (cmd.fire && sel_fire)
        begin
            rem_next = period_reg; pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg <= FREE_ID;
            pend_reg  <= 1'b0;
        end
        else
        begin
            ident_reg <= ident_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= period_next;
        rem_reg    <= rem_next;
        handle_reg <= handle_next;
    end
endmodule

[rtl/core/ptt_ring.sv]
// Deferred handle ring with head and tail pointers.
module ptt_ring (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [15:0]             push_data,
    input  logic                    pop,
    output logic                    full,
    output logic                    empty_at,
    input  logic [ptt_pkg::RING_W-1:0] snap,
    output logic [ptt_pkg::RING_W-1:0] tail,
    output logic [15:0]             head_data
);
    import ptt_pkg::*;

    logic [15:0] mem_reg [RING_DEPTH];
    logic [RING_W-1:0] head_reg, head_next, tail_reg, tail_next;

    function automatic logic [RING_W-1:0] nxt(input logic [RING_W-1:0] p);
        nxt = (p == RING_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (nxt(tail_reg) == head_reg);
    assign empty_at  = (head_reg == snap);
    assign tail      = tail_reg;
    assign head_data = mem_reg[head_reg];

    always_comb
    begin
        head_next = pop ? nxt(head_reg) : head_reg;
        tail_next = (push && !full) ? nxt(tail_reg) : tail_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full) mem_reg[tail_reg] <= push_data;
    end
endmodule

[rtl/core/periodic_task_timer_table.sv]
// Top level of the periodic task timer table with its deferred ring.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------
//  in      | in_valid/in_stall  | in_item (mode, id, interval, token)
//  out     | out_valid/out_stall| out_item (kind, status, id, handle, last)
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A table command updates the cells at its accepting edge; its status item is
// registered and presented from ST_OUT, and the input stays stalled until that
// item has been taken. A poll pops the ring in ST_DRAIN and emits each nonzero
// handle, fires the pending slots in ST_FIRE and emits each one, and ends with
// the done item built in ST_DONE; out_stall holds a presented item until taken.
// Reset clears slot identities, pending flags and the ring pointers.
`include "periodic_task_timer_table_assert.svh"
module periodic_task_timer_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ptt_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output ptt_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);
    import ptt_pkg::*;

    fsm_t state_reg, state_next;
    out_item_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic [15:0] min_reg, max_reg;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [RING_W-1:0] snap_reg, snap_next, tail;
    logic accept;

    cell_cmd_t cmd;
    chain_t chain [TASK_SLOTS+1];
    logic [TASK_SLOTS-1:0] is_free, is_pend, sel_add, sel_fire;
    slot_t slots [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] free_seen, pend_seen;
    logic ring_full, ring_empty, ring_pop, ring_push;
    logic [15:0] head_data;
    logic room, ivl_ok;
    logic [SLOT_W-1:0] fire_idx;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign chain[0]  = '0;
    assign room      = (n_reg < CNT_W'(MAX_RESULTS - 1));
    assign ivl_ok    = (in_item.interval >= min_reg) && (in_item.interval <= max_reg);

    // First free and first pending slot, found by prefix bits along the chain.
    always_comb
    begin
        fire_idx = '0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            free_seen[i] = chain[i].have_free;
            pend_seen[i] = chain[i].have_pend;
            sel_add[i]   = is_free[i] && !free_seen[i];
            sel_fire[i]  = is_pend[i] && !pend_seen[i];
            if (sel_fire[i]) fire_idx = SLOT_W'(i);
        end
    end

    generate
        for (genvar g = 0; g < TASK_SLOTS; g++)
        begin : g_cell
            ptt_cell u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd), .sel_add(sel_add[g]),
                .sel_fire(sel_fire[g]), .chain_in(chain[g]), .chain_out(chain[g+1]),
                .is_free(is_free[g]), .is_pend(is_pend[g]),
                .slot(slots[g])
            );
        end
    endgenerate

    ptt_ring u_ring (
        .clk(clk), .rst_n(rst_n), .push(ring_push), .push_data(in_item.token),
        .pop(ring_pop), .full(ring_full), .empty_at(ring_empty), .snap(snap_reg),
        .tail(tail), .head_data(head_data)
    );

    // Command decode for the cells and ring in the accept cycle, and fire in ST_FIRE.
    always_comb
    begin
        cmd = '0;
        cmd.interval = in_item.interval;
        cmd.token    = in_item.token;
        cmd.task_id  = in_item.task_id;
        ring_push    = 1'b0;
        if (accept && in_item.task_id != FREE_ID)
        begin
            cmd.add    = (in_item.mode == MODE_ADD) && ivl_ok && !chain[TASK_SLOTS].found;
            cmd.remove = (in_item.mode == MODE_REMOVE);
            cmd.set    = (in_item.mode == MODE_SET) && ivl_ok;
        end
        if (accept)
        begin
            cmd.tick  = (in_item.mode == MODE_TICK);
            ring_push = (in_item.mode == MODE_ENQ);
        end
        cmd.fire = (state_reg == ST_FIRE) && !out_valid_reg && room && chain[TASK_SLOTS].have_pend;
    end
    assign ring_pop = (state_reg == ST_DRAIN) && !out_valid_reg && !ring_empty && room;

    // Next state. The final item of an input is held in ST_OUT until the
    // consumer takes it, so the block is empty whenever it is idle.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept) state_next = (in_item.mode == MODE_POLL) ? ST_DRAIN : ST_OUT;
            ST_DRAIN:
                if (!out_valid_reg && (ring_empty || !room)) state_next = ST_FIRE;
            ST_FIRE:
                if (!out_valid_reg && (!chain[TASK_SLOTS].have_pend || !room))
                    state_next = ST_DONE;
            ST_DONE:
                if (!out_valid_reg) state_next = ST_OUT;
            ST_OUT:
                if (out_valid_reg && !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and data path.
    always_comb
    begin
        out_next = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        n_next = n_reg;
        snap_next = snap_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    n_next = '0;
                    snap_next = tail;
                    out_next = '{kind: KIND_STATUS, status: ST_OK, fired_id: 8'd0,
                                 handle: 16'd0, last: 1'b1};
                    case (in_item.mode)
                        MODE_ADD:
                            if (in_item.task_id == FREE_ID) out_next.status = ST_INVALID_ID;
                            else if (!ivl_ok) out_next.status = ST_BAD_INTERVAL;
                            else if (chain[TASK_SLOTS].found) out_next.status = ST_DUP;
                            else if (!chain[TASK_SLOTS].have_free)
                                out_next.status = ST_NO_SLOT;
                        MODE_REMOVE:
                            if (in_item.task_id == FREE_ID) out_next.status = ST_INVALID_ID;
                            else if (!chain[TASK_SLOTS].found) out_next.status = ST_NOT_FOUND;
                        MODE_SET:
                            if (in_item.task_id == FREE_ID) out_next.status = ST_INVALID_ID;
                            else if (!ivl_ok) out_next.status = ST_BAD_INTERVAL;
                            else if (!chain[TASK_SLOTS].found) out_next.status = ST_NOT_FOUND;
                        MODE_ENQ:
                            if (ring_full) out_next.status = ST_FULL;
                        default: out_next.status = ST_OK;
                    endcase
                end
            ST_DRAIN:
                if (ring_pop && head_data != 16'd0)
                begin
                    out_next = '{kind: KIND_DRAIN, status: ST_OK, fired_id: 8'd0,
                                 handle: head_data, last: 1'b0};
                    out_valid_next = 1'b1;
                    n_next = n_reg + 1'b1;
                end
            ST_FIRE:
                if (cmd.fire)
                begin
                    out_next = '{kind: KIND_FIRE, status: ST_OK,
                                 fired_id: slots[fire_idx].ident,
                                 handle: slots[fire_idx].handle, last: 1'b0};
                    out_valid_next = 1'b1;
                    n_next = n_reg + 1'b1;
                end
            ST_DONE:
                if (!out_valid_reg)
                    out_next = '{kind: KIND_STATUS, status: ST_OK, fired_id: 8'd0,
                                 handle: 16'd0, last: 1'b1};
            ST_OUT:
                if (!out_valid_reg) out_valid_next = 1'b1;
            default: out_valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            min_reg       <= 16'd1;
            max_reg       <= 16'hFFFF;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MIN) min_reg <= cfg_data;
                if (cfg_index == CFG_MAX) max_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        n_reg    <= n_next;
        snap_reg <= snap_next;
    end

    `PTT_ASSERT_IMPL(a_idle_quiet, clk, rst_n, state_reg == ST_IDLE, !out_valid_reg,
        "output valid while idle")
    `PTT_ASSERT_NEXT(a_fire_pending, clk, rst_n, cmd.fire, $past(chain[TASK_SLOTS].have_pend),
        "fire without pending slot")
    `PTT_ASSERT_IMPL(a_one_hot_fire, clk, rst_n, 1'b1, $onehot0(sel_fire),
        "more than one slot selected to fire")
    `PTT_ASSERT_IMPL(a_last_done, clk, rst_n, out_valid_reg && out_reg.kind != KIND_STATUS,
        !out_reg.last, "handle item marked last")
endmodule
